### src/first_fit_heap_allocator_assert.svh
// Assertion macros shared by the allocator's checker.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define FFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ffa_pkg.sv
// Shared constants and types of the first-fit heap allocator.
package ffa_pkg;

    localparam int POOL_BYTES  = 8388608;
    localparam int MAX_EXTENTS = 64;
    localparam int IDX_W       = $clog2(MAX_EXTENTS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int START_W     = 23;
    localparam int BYTES_W     = 24;
    localparam int ADDR_W      = 48;
    localparam int REQ_W       = 24;
    localparam int STATUS_W    = 3;

    localparam logic [BYTES_W-1:0] HDR_WORD = BYTES_W'(8);
    localparam logic [BYTES_W-1:0] MIN_BLK  = BYTES_W'(32);

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ALLOC_OK   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ALLOC_FAIL = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREED      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREE_BAD   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREE_FULL  = 3'd4;

    // Function codes.
    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    // One free extent as stored in the table.
    typedef struct packed {
        logic [START_W-1:0] start;
        logic [BYTES_W-1:0] bytes;
    } extent_t;

endpackage

### src/ffa_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
module ffa_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 47,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/first_fit_heap_allocator.sv
// First-fit heap allocator: a free-extent table in RAM walked by a small sequencer.
// Each beat allocates a block (first fit, split when the rest is at least 32 bytes) or
// frees one (merge with the following extent, then the preceding one, else insert at the
// head). The table sits in one RAM with one read and one write per cycle. Every scan step
// is a read, then a check or write. Removing an entry moves each later entry by a check,
// a read and a write, and an insert moves each entry by a read and a write. A free does
// the most work when it absorbs the following extent, drops it from the table, finds no
// preceding extent and then inserts at the head. in_ready is high only between items. The
// result waits in an output register while the next beat is taken. No clearing pass is
// needed after reset.
module first_fit_heap_allocator
    import ffa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [ADDR_W-1:0]   cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                func,
    input  logic [REQ_W-1:0]    request_bytes,
    input  logic [ADDR_W-1:0]   release_address,
    input  logic [BYTES_W-1:0]  header_bytes,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [ADDR_W-1:0]   payload_address,
    output logic [BYTES_W-1:0]  granted_bytes
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_A_PREP   = 5'd1;
    localparam logic [4:0] S_A_RD     = 5'd2;
    localparam logic [4:0] S_A_CHK    = 5'd3;
    localparam logic [4:0] S_F_CHK1   = 5'd4;
    localparam logic [4:0] S_F_CHK2   = 5'd5;
    localparam logic [4:0] S_F_CHK3   = 5'd6;
    localparam logic [4:0] S_N_RD     = 5'd7;
    localparam logic [4:0] S_N_CHK    = 5'd8;
    localparam logic [4:0] S_P_START  = 5'd9;
    localparam logic [4:0] S_P_RD     = 5'd10;
    localparam logic [4:0] S_P_CHK    = 5'd11;
    localparam logic [4:0] S_I_START  = 5'd12;
    localparam logic [4:0] S_IN_RD    = 5'd13;
    localparam logic [4:0] S_IN_WR    = 5'd14;
    localparam logic [4:0] S_HEAD_WR  = 5'd15;
    localparam logic [4:0] S_SH_START = 5'd16;
    localparam logic [4:0] S_SH_RD    = 5'd17;
    localparam logic [4:0] S_SH_WR    = 5'd18;
    localparam logic [4:0] S_DONE     = 5'd19;

    localparam logic [CNT_W-1:0]   CNT_MAX  = CNT_W'(MAX_EXTENTS);
    localparam logic [BYTES_W:0]   POOL_X   = (BYTES_W+1)'(POOL_BYTES);
    localparam logic [ADDR_W:0]    POOL_W   = (ADDR_W+1)'(POOL_BYTES);
    localparam logic [BYTES_W-1:0] POOL_B   = BYTES_W'(POOL_BYTES);

    logic [4:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   base_reg;
    logic                func_reg;
    logic [REQ_W-1:0]    req_reg;
    logic [ADDR_W-1:0]   wide_reg, wide_next;
    logic [BYTES_W-1:0]  sz_reg, sz_next;
    logic [START_W-1:0]  off_reg, off_next;
    logic [BYTES_W-1:0]  end_reg, end_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                head_init_reg;
    logic                rd_zero_reg;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic [BYTES_W-1:0]  res_bytes_reg, res_bytes_next;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [BYTES_W-1:0]  out_bytes_reg;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    extent_t             mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;
    logic                mem_re;
    extent_t             mem_rdata;
    extent_t             ext;

    logic [BYTES_W:0]    need_raw;
    logic [BYTES_W:0]    sum_x;
    logic                next_last;
    logic                out_load;

    ffa_ram #(
        .DEPTH (MAX_EXTENTS),
        .WIDTH ($bits(extent_t))
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Entry 0 reads as the whole pool until it is first written.
    always_comb
    begin
        ext = mem_rdata;
        if (rd_zero_reg && !head_init_reg)
        begin
            ext.start = '0;
            ext.bytes = POOL_B;
        end
    end

    assign need_raw  = ({1'b0, req_reg} + (BYTES_W+1)'(23)) & ~(BYTES_W+1)'(15);
    assign next_last = ({1'b0, idx_reg} + CNT_W'(1)) >= cnt_reg;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == S_IDLE);

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        wide_next       = wide_reg;
        sz_next         = sz_reg;
        off_next        = off_reg;
        end_next        = end_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_bytes_next  = res_bytes_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = ext;
        mem_raddr       = idx_reg;
        mem_re          = 1'b0;
        sum_x           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    wide_next       = release_address;
                    sz_next         = header_bytes;
                    idx_next        = '0;
                    res_addr_next   = '0;
                    res_bytes_next  = '0;
                    res_status_next = (func == FN_FREE) ? ST_FREE_BAD : ST_ALLOC_FAIL;
                    state_next      = (func == FN_FREE) ? S_F_CHK1 : S_A_PREP;
                end
            end
            S_A_PREP:
            begin
                sz_next = (need_raw < {1'b0, MIN_BLK}) ? MIN_BLK : need_raw[BYTES_W-1:0];
                if (req_reg == '0 || {1'b0, req_reg} > POOL_X || cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_A_RD;
                end
            end
            S_A_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                sum_x = {1'b0, sz_reg} + {1'b0, MIN_BLK};
                if (ext.bytes >= sz_reg)
                begin
                    res_status_next = ST_ALLOC_OK;
                    res_addr_next   = base_reg + ADDR_W'(ext.start) + ADDR_W'(HDR_WORD);
                    if ({1'b0, ext.bytes} >= sum_x)
                    begin
                        mem_we          = 1'b1;
                        mem_wdata.start = ext.start + sz_reg[START_W-1:0];
                        mem_wdata.bytes = ext.bytes - sz_reg;
                        res_bytes_next  = sz_reg;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        res_bytes_next = ext.bytes;
                        state_next     = S_SH_START;
                    end
                end
                else if (next_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_A_RD;
                end
            end
            S_F_CHK1:
            begin
                if (wide_reg < ADDR_W'(HDR_WORD) || sz_reg < MIN_BLK)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    wide_next  = wide_reg - ADDR_W'(HDR_WORD);
                    state_next = S_F_CHK2;
                end
            end
            S_F_CHK2:
            begin
                if (wide_reg < base_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    wide_next  = wide_reg - base_reg;
                    state_next = S_F_CHK3;
                end
            end
            S_F_CHK3:
            begin
                if (({1'b0, wide_reg} + (ADDR_W+1)'(sz_reg)) > POOL_W)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    off_next = wide_reg[START_W-1:0];
                    end_next = BYTES_W'(wide_reg[START_W-1:0]) + sz_reg;
                    if ((BYTES_W'(wide_reg[START_W-1:0]) + sz_reg) < POOL_B && cnt_reg != '0)
                    begin
                        state_next = S_N_RD;
                    end
                    else
                    begin
                        state_next = S_P_START;
                    end
                end
            end
            S_N_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_N_CHK;
            end
            S_N_CHK:
            begin
                sum_x = {1'b0, sz_reg} + {1'b0, ext.bytes};
                if (BYTES_W'(ext.start) == end_reg)
                begin
                    sz_next    = sum_x[BYTES_W] ? '1 : sum_x[BYTES_W-1:0];
                    state_next = S_SH_START;
                end
                else if (next_last)
                begin
                    state_next = S_P_START;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_N_RD;
                end
            end
            S_P_START:
            begin
                idx_next   = '0;
                state_next = (off_reg != '0 && cnt_reg != '0) ? S_P_RD : S_I_START;
            end
            S_P_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_P_CHK;
            end
            S_P_CHK:
            begin
                sum_x = {1'b0, sz_reg} + {1'b0, ext.bytes};
                if (({2'b0, ext.start} + {1'b0, ext.bytes}) == (BYTES_W+1)'(off_reg))
                begin
                    mem_we          = 1'b1;
                    mem_wdata.bytes = sum_x[BYTES_W] ? '1 : sum_x[BYTES_W-1:0];
                    res_status_next = ST_FREED;
                    state_next      = S_DONE;
                end
                else if (next_last)
                begin
                    state_next = S_I_START;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_P_RD;
                end
            end
            S_I_START:
            begin
                idx_next = cnt_reg[IDX_W-1:0];
                if (cnt_reg >= CNT_MAX)
                begin
                    res_status_next = ST_FREE_FULL;
                    state_next      = S_DONE;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = S_HEAD_WR;
                end
                else
                begin
                    state_next = S_IN_RD;
                end
            end
            S_IN_RD:
            begin
                mem_raddr  = idx_reg - IDX_W'(1);
                mem_re     = 1'b1;
                state_next = S_IN_WR;
            end
            S_IN_WR:
            begin
                mem_we     = 1'b1;
                idx_next   = idx_reg - IDX_W'(1);
                state_next = (idx_reg == IDX_W'(1)) ? S_HEAD_WR : S_IN_RD;
            end
            S_HEAD_WR:
            begin
                mem_we          = 1'b1;
                mem_waddr       = '0;
                mem_wdata.start = off_reg;
                mem_wdata.bytes = sz_reg;
                cnt_next        = cnt_reg + CNT_W'(1);
                res_status_next = ST_FREED;
                state_next      = S_DONE;
            end
            S_SH_START:
            begin
                if (next_last)
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = (func_reg == FN_FREE) ? S_P_START : S_DONE;
                end
                else
                begin
                    state_next = S_SH_RD;
                end
            end
            S_SH_RD:
            begin
                mem_raddr  = idx_reg + IDX_W'(1);
                mem_re     = 1'b1;
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                mem_we     = 1'b1;
                idx_next   = idx_reg + IDX_W'(1);
                state_next = S_SH_START;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= CNT_W'(1);
            head_init_reg <= 1'b0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
            rd_zero_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (mem_we && mem_waddr == '0)
            begin
                head_init_reg <= 1'b1;
            end
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (mem_re)
            begin
                rd_zero_reg <= (mem_raddr == '0);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            func_reg <= func;
            req_reg  <= request_bytes;
        end
        wide_reg       <= wide_next;
        sz_reg         <= sz_next;
        off_reg        <= off_next;
        end_reg        <= end_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_bytes_reg  <= res_bytes_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_bytes_reg  <= res_bytes_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign payload_address = out_addr_reg;
    assign granted_bytes   = out_bytes_reg;

endmodule

### src/ffa_checker.sv
// Port-level checker for the first-fit heap allocator and its bind.
`include "first_fit_heap_allocator_assert.svh"

module ffa_port_checker
    import ffa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic [ADDR_W-1:0]   payload_address,
    input logic [BYTES_W-1:0]  granted_bytes
);

    // A stalled result beat holds.
    `FFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(payload_address), "result changed while stalled")

    // Once a beat is taken the block is busy in the next cycle.
    `FFA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken twice in a row")

    // Only defined status codes appear.
    `FFA_ASSERT_NOW(a_status_code, out_valid, status == ST_ALLOC_OK || status == ST_ALLOC_FAIL || status == ST_FREED || status == ST_FREE_BAD || status == ST_FREE_FULL, "undefined status")

    // Every result other than a granted block carries zero address and size.
    `FFA_ASSERT_NOW(a_zero_fields, out_valid && status != ST_ALLOC_OK, payload_address == '0 && granted_bytes == '0, "nonzero fields on failure")

    // A granted block is at least the minimum block size.
    `FFA_ASSERT_NOW(a_min_grant, out_valid && status == ST_ALLOC_OK, granted_bytes >= MIN_BLK, "granted block too small")

endmodule

bind first_fit_heap_allocator ffa_port_checker u_ffa_port_checker (.*);

### sim/ffa_checker.sv
// Allocator checker: watches both channels, predicts each result and compares it.
module ffa_checker
    import ffa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [ADDR_W-1:0]   cfg_wdata,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                func,
    input  logic [REQ_W-1:0]    request_bytes,
    input  logic [ADDR_W-1:0]   release_address,
    input  logic [BYTES_W-1:0]  header_bytes,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [STATUS_W-1:0] status,
    input  logic [ADDR_W-1:0]   payload_address,
    input  logic [BYTES_W-1:0]  granted_bytes,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned ADDR_MASK = 64'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
        logic [BYTES_W-1:0]  bytes;
    } alloc_result_t;

    // Shadow copy of the free-extent table.
    logic [START_W-1:0] free_start [MAX_EXTENTS];
    logic [BYTES_W-1:0] free_bytes [MAX_EXTENTS];
    int                 free_count;
    logic [ADDR_W-1:0]  pool_base;
    alloc_result_t      result_q [$];

    // Print one mismatch line and count it.
    task automatic report(input string what, input longint unsigned got,
                          input longint unsigned want);
        $display("[%0t] mismatch %s: got %0h, wanted %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic logic [BYTES_W-1:0] clamp_bytes(input longint unsigned v);
        return (v > 64'hFF_FFFF) ? 24'hFF_FFFF : v[BYTES_W-1:0];
    endfunction

    function automatic void remove_extent(input int idx);
        for (int k = idx; k + 1 < free_count; k++)
        begin
            free_start[k] = free_start[k+1];
            free_bytes[k] = free_bytes[k+1];
        end
        if (free_count > 0)
            free_count--;
    endfunction

    // First-fit allocation with split when the remainder is big enough.
    function automatic alloc_result_t predict_alloc(input logic [REQ_W-1:0] req);
        alloc_result_t   r;
        longint unsigned need;
        longint unsigned sz;
        longint unsigned st;
        r = '{status: ST_ALLOC_FAIL, addr: '0, bytes: '0};
        if (req == 0 || req > POOL_BYTES)
            return r;
        need = (longint'(req) + 8 + 15) & ~64'd15;
        if (need < 32)
            need = 32;
        for (int i = 0; i < free_count; i++)
        begin
            sz = free_bytes[i];
            if (sz >= need)
            begin
                st = free_start[i];
                if (sz >= need + 32)
                begin
                    free_start[i] = START_W'(st + need);
                    free_bytes[i] = BYTES_W'(sz - need);
                    r.bytes = BYTES_W'(need);
                end
                else
                begin
                    remove_extent(i);
                    r.bytes = BYTES_W'(sz);
                end
                r.status = ST_ALLOC_OK;
                r.addr = ADDR_W'((longint'(pool_base) + st + 8) & ADDR_MASK);
                return r;
            end
        end
        return r;
    endfunction

    // Free: validate, absorb the extent after, join the one before, else insert at head.
    function automatic alloc_result_t predict_free(input logic [ADDR_W-1:0] addr,
                                                   input logic [BYTES_W-1:0] hsz);
        alloc_result_t   r;
        longint unsigned hdr;
        longint unsigned off;
        longint unsigned sz;
        longint unsigned blk_end;
        r = '{status: ST_FREE_BAD, addr: '0, bytes: '0};
        if (addr < 8)
            return r;
        hdr = longint'(addr) - 8;
        sz = hsz;
        if (sz < 32 || hdr < pool_base)
            return r;
        off = hdr - pool_base;
        if (off + sz > POOL_BYTES)
            return r;
        blk_end = off + sz;
        if (blk_end < POOL_BYTES)
        begin
            for (int i = 0; i < free_count; i++)
            begin
                if (longint'(free_start[i]) == blk_end)
                begin
                    sz = clamp_bytes(sz + free_bytes[i]);
                    remove_extent(i);
                    break;
                end
            end
        end
        if (off > 0)
        begin
            for (int i = 0; i < free_count; i++)
            begin
                if (longint'(free_start[i]) + free_bytes[i] == off)
                begin
                    free_bytes[i] = clamp_bytes(longint'(free_bytes[i]) + sz);
                    r.status = ST_FREED;
                    return r;
                end
            end
        end
        if (free_count >= MAX_EXTENTS)
        begin
            r.status = ST_FREE_FULL;
            return r;
        end
        for (int k = free_count; k > 0; k--)
        begin
            free_start[k] = free_start[k-1];
            free_bytes[k] = free_bytes[k-1];
        end
        free_start[0] = START_W'(off);
        free_bytes[0] = clamp_bytes(sz);
        free_count++;
        r.status = ST_FREED;
        return r;
    endfunction

    // Track configuration, predict on each input beat, compare on each output beat.
    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_EXTENTS; i++)
            begin
                free_start[i] = '0;
                free_bytes[i] = '0;
            end
            free_bytes[0] = BYTES_W'(POOL_BYTES);
            free_count = 1;
            pool_base = '0;
            result_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                pool_base = cfg_wdata;
            if (in_valid && in_ready)
            begin
                if (func == FN_ALLOC)
                    result_q.push_back(predict_alloc(request_bytes));
                else
                    result_q.push_back(predict_free(release_address, header_bytes));
            end
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                    report("unexpected result beat", status, 0);
                else
                begin
                    want = result_q.pop_front();
                    if (status !== want.status)
                        report("status", status, want.status);
                    if (payload_address !== want.addr)
                        report("payload_address", payload_address, want.addr);
                    if (granted_bytes !== want.bytes)
                        report("granted_bytes", granted_bytes, want.bytes);
                end
            end
            pending = result_q.size();
        end
    end
endmodule

### sim/tb_top.sv
// Testbench top for the first-fit heap allocator: stimulus, handshake pacing, verdict.
module tb_top;
    import ffa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_CYCLES = 6 * MAX_EXTENTS + 40;
    localparam longint unsigned ADDR_MASK = 64'hFFFF_FFFF_FFFF;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [ADDR_W-1:0]   cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                func = FN_ALLOC;
    logic [REQ_W-1:0]    request_bytes = '0;
    logic [ADDR_W-1:0]   release_address = '0;
    logic [BYTES_W-1:0]  header_bytes = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   payload_address;
    logic [BYTES_W-1:0]  granted_bytes;
    int                  fail_count;
    int                  pending;

    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    bit                  hold_request = 1'b0;
    int                  hold_left = 0;
    longint unsigned     cycle_count = 0;
    logic [ADDR_W-1:0]   cur_base = '0;
    // Blocks currently held by the stimulus, as pool offsets and sizes.
    longint unsigned     held_off [$];
    logic [BYTES_W-1:0]  held_size [$];

    always #5 clk = ~clk;

    first_fit_heap_allocator dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .func(func),
        .request_bytes(request_bytes), .release_address(release_address),
        .header_bytes(header_bytes), .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .payload_address(payload_address), .granted_bytes(granted_bytes)
    );

    ffa_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .func(func),
        .request_bytes(request_bytes), .release_address(release_address),
        .header_bytes(header_bytes), .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .payload_address(payload_address), .granted_bytes(granted_bytes),
        .fail_count(fail_count), .pending(pending)
    );

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Remember granted blocks so later frees can return them.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready && status == ST_ALLOC_OK)
        begin
            held_off.push_back((longint'(payload_address) - 8 - cur_base) & ADDR_MASK);
            held_size.push_back(granted_bytes);
        end
    end

    // Receiver pacing, with a long hold-off on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready = 1'b0;
            end
            else
                out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Offer one beat and hold it until it is taken, then maybe go idle.
    task automatic send(input logic f, input logic [REQ_W-1:0] req,
                        input logic [ADDR_W-1:0] addr, input logic [BYTES_W-1:0] hsz);
        func = f;
        request_bytes = req;
        release_address = addr;
        header_bytes = hsz;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic alloc(input logic [REQ_W-1:0] req);
        send(FN_ALLOC, req, ADDR_W'({$urandom, $urandom}), BYTES_W'($urandom));
    endtask

    task automatic release_block(input longint unsigned off, input logic [BYTES_W-1:0] sz);
        send(FN_FREE, REQ_W'($urandom), ADDR_W'((cur_base + off + 8) & ADDR_MASK), sz);
    endtask

    // Wait until every expected result has come and the block has settled.
    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_base(input logic [ADDR_W-1:0] v);
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        cur_base = v;
    endtask

    // One random beat: mostly allocations and matching frees, some noise.
    task automatic random_beat();
        int r;
        int idx;
        logic [REQ_W-1:0] req;
        r = $urandom_range(0, 99);
        if (r < 50 || (r < 88 && held_off.size() == 0))
        begin
            case ($urandom_range(0, 19))
                0:       req = '0;
                1:       req = REQ_W'($urandom);
                2:       req = REQ_W'($urandom_range(65536, POOL_BYTES));
                3, 4:    req = REQ_W'($urandom_range(1, 65536));
                default: req = REQ_W'($urandom_range(1, 2048));
            endcase
            alloc(req);
        end
        else if (r < 88)
        begin
            idx = $urandom_range(0, held_off.size() - 1);
            release_block(held_off[idx], held_size[idx]);
            held_off.delete(idx);
            held_size.delete(idx);
        end
        else
        begin
            case ($urandom_range(0, 4))
                0: send(FN_FREE, REQ_W'($urandom), ADDR_W'({$urandom, $urandom}),
                        BYTES_W'($urandom));
                1: send(FN_FREE, REQ_W'($urandom), ADDR_W'($urandom_range(0, 7)), 24'd32);
                2: release_block(16 * $urandom_range(0, 4096), BYTES_W'($urandom_range(0, 31)));
                3: release_block(POOL_BYTES - 16 * $urandom_range(1, 4), 24'd96);
                default:
                begin
                    // Double free of a block that stays held.
                    if (held_off.size() != 0)
                    begin
                        idx = $urandom_range(0, held_off.size() - 1);
                        release_block(held_off[idx], held_size[idx]);
                    end
                    else
                        alloc(REQ_W'($urandom_range(1, 512)));
                end
            endcase
        end
    endtask

    // Chop the pool into many small blocks and free every other one to fill the table.
    task automatic fragment_pool();
        int n;
        for (int i = 0; i < 140; i++)
            alloc(REQ_W'($urandom_range(1, 120)));
        drain();
        n = held_off.size();
        for (int i = n - 1; i >= 0; i -= 2)
        begin
            release_block(held_off[i], held_size[i]);
            held_off.delete(i);
            held_size.delete(i);
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic [ADDR_W-1:0] bases [4];
        bases[0] = '0;
        bases[1] = 48'hFFFF_FFFF_FFF0;
        bases[2] = 48'h0000_0000_1000;
        bases[3] = ADDR_W'({$urandom, $urandom}) & ~48'hF;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        write_base('0);

        // Directed: size limits, whole-pool grant, empty table, invalid frees.
        alloc('0);
        alloc(REQ_W'(POOL_BYTES + 1));
        alloc(24'hFF_FFFF);
        alloc(REQ_W'(POOL_BYTES - 8));
        alloc(24'd1);
        drain();
        release_block(held_off[0], held_size[0]);
        held_off.delete(0);
        held_size.delete(0);
        alloc(24'd1);
        alloc(24'd24);
        alloc(24'd25);
        alloc(24'd40);
        send(FN_FREE, '0, '0, 24'd32);
        send(FN_FREE, '0, 48'd7, 24'd32);
        release_block(0, 24'd31);
        release_block(POOL_BYTES - 16, 24'd32);
        drain();
        // Free the middle block first, then its neighbors to exercise both merges.
        release_block(held_off[1], held_size[1]);
        release_block(held_off[0], held_size[0]);
        release_block(held_off[2], held_size[2]);
        release_block(held_off[3], held_size[3]);
        held_off.delete();
        held_size.delete();
        drain();

        // Phases with different pacing and pool base.
        for (int ph = 0; ph < 4; ph++)
        begin
            write_base(bases[ph]);
            if (ph == 2)
                send(FN_FREE, '0, 48'h10, 24'd32);
            send_idle_pct = (ph == 1) ? 68 : (ph == 3) ? 18 : 0;
            recv_stall_pct = (ph == 2) ? 68 : (ph == 3) ? 18 : 0;
            if (ph == 0)
                fragment_pool();
            for (int i = 0; i < 300; i++)
            begin
                if (ph == 0 && i == 50)
                    hold_request = 1'b1;
                if (i == 150)
                begin
                    in_valid = 1'b0;
                    while (pending != 0)
                        @(negedge clk);
                end
                random_beat();
            end
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

### first_fit_heap_allocator.f
+incdir+src
src/ffa_pkg.sv
src/ffa_ram.sv
src/first_fit_heap_allocator.sv
src/ffa_checker.sv
sim/ffa_checker.sv
sim/tb_top.sv
